@@ hw/rtl/circle_span_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// Circle span rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled under arst_n.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SPAN_RASTERIZER_MACROS_SVH
`define CIRCLE_SPAN_RASTERIZER_MACROS_SVH

// same-cycle implication
`define CSR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("circle span rasterizer: check failed");

// next-cycle implication
`define CSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("circle span rasterizer: check failed");

`endif

@@ hw/rtl/csr_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer package
// Field widths, register codes, sequencer states and unit handshake types.
// ----------------------------------------------------------------------------
package csr_pkg;

	localparam int COORD_W  = 12;
	localparam int BOTTOM_W = 13;
	localparam int RAD_W    = 6;
	localparam int LEN_W    = 7;
	localparam int COLOR_W  = 16;
	localparam int ROOT_W   = 6;
	localparam int RADICAND_W = 2 * ROOT_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd600;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_EMIT
	} csr_state_t;

	typedef struct packed {
		logic                  start;
		logic [RADICAND_W-1:0] radicand;
	} csr_sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} csr_sqrt_rsp_t;

endpackage

@@ hw/rtl/csr_if.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer channels
// Command channel and span result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface csr_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [csr_pkg::COORD_W-1:0] center_x;
	logic [csr_pkg::COORD_W-1:0] center_y;
	logic [csr_pkg::RAD_W-1:0]   radius;
	logic [csr_pkg::COLOR_W-1:0] fill_color;

	modport source (output valid, center_x, center_y, radius, fill_color, input ready);
	modport sink   (input valid, center_x, center_y, radius, fill_color, output ready);
endinterface

interface csr_span_if;
	logic                         valid;
	logic                         ready;
	logic [csr_pkg::COORD_W-1:0]  top_row;
	logic [csr_pkg::BOTTOM_W-1:0] bottom_row;
	logic [csr_pkg::COORD_W-1:0]  span_start;
	logic [csr_pkg::LEN_W-1:0]    span_length;
	logic [csr_pkg::COLOR_W-1:0]  span_color;
	logic                         top_drawn;
	logic                         bottom_drawn;
	logic                         last_span;

	modport source (output valid, top_row, bottom_row, span_start, span_length, span_color,
		top_drawn, bottom_drawn, last_span, input ready);
	modport sink   (input valid, top_row, bottom_row, span_start, span_length, span_color,
		top_drawn, bottom_drawn, last_span, output ready);
endinterface

@@ hw/rtl/csr_isqrt.sv @@
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root, one result bit per cycle, trial square and compare.
// ----------------------------------------------------------------------------
module csr_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csr_pkg::csr_sqrt_req_t req,
	output csr_pkg::csr_sqrt_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [csr_pkg::ROOT_W-1:0]     bit_q;
	logic [csr_pkg::ROOT_W-1:0]     root_q;
	logic [csr_pkg::RADICAND_W-1:0] n_q;
	logic [csr_pkg::ROOT_W-1:0]     trial;
	logic [csr_pkg::RADICAND_W-1:0] trial_ext;
	logic [csr_pkg::RADICAND_W-1:0] trial_sq;

	assign trial     = root_q | bit_q;
	assign trial_ext = csr_pkg::RADICAND_W'(trial);
	assign trial_sq  = trial_ext * trial_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q    <= req.radicand;
			root_q <= '0;
			bit_q  <= {1'b1, {(csr_pkg::ROOT_W-1){1'b0}}};
		end else if (busy_q) begin
			if (trial_sq <= n_q) begin
				root_q <= trial;
			end
			bit_q <= bit_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

@@ hw/rtl/circle_span_rasterizer.sv @@
// ----------------------------------------------------------------------------
// Circle span rasterizer
// Walks dy = 0..radius of a filled circle and emits one clipped span per dy, for a top and a bottom row.
//
//   channel  dir  transfer            contents
//   cmd      in   valid && ready      center_x, center_y, radius, fill_color
//   span     out  valid && ready      rows, start, length, color, flags
//   cfg      in   cfg_we              screen_width (0), screen_height (1)
//
// A command is taken only when the sequencer is idle.
// Each row runs 6 square root steps, waits for the root done flag, then emits its span.
// A stalled span holds in the output register; the sequencer waits in emit.
// Reset restores 800 x 600 and idles the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
`include "circle_span_rasterizer_macros.svh"

module circle_span_rasterizer #(
	parameter int MAX_RADIUS = 63
) (
	input  logic                           clk,
	input  logic                           arst_n,
	csr_cmd_if.sink                        cmd,
	csr_span_if.source                     span,
	input  logic                           cfg_we,
	input  logic [csr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csr_pkg::CFG_DATA_W-1:0] cfg_data
);

	csr_pkg::csr_state_t    state_q, state_d;
	csr_pkg::csr_sqrt_req_t sq_req;
	csr_pkg::csr_sqrt_rsp_t sq_rsp;

	logic [csr_pkg::COORD_W-1:0]    width_q, height_q;
	logic [csr_pkg::COORD_W-1:0]    cx_q, cy_q;
	logic [csr_pkg::COLOR_W-1:0]    color_q;
	logic [csr_pkg::RAD_W-1:0]      r_q, dy_q, r_sat;
	logic [csr_pkg::RADICAND_W-1:0] n_q, n_next, r_sq;

	logic cmd_fire, emit_fire, last_row;

	logic                          out_valid_q;
	logic [csr_pkg::COORD_W-1:0]   top_q, start_q;
	logic [csr_pkg::BOTTOM_W-1:0]  bottom_q;
	logic [csr_pkg::LEN_W-1:0]     len_q;
	logic [csr_pkg::COLOR_W-1:0]   scolor_q;
	logic                          top_drawn_q, bottom_drawn_q, last_q;

	logic [csr_pkg::COORD_W-1:0]  dx_ext, dy_ext, start_c, top_c;
	logic [csr_pkg::BOTTOM_W-1:0] bottom_c, end_c;
	logic [csr_pkg::LEN_W-1:0]    len_full, len_c;
	logic start_ok, top_ok, col_ok, top_drawn_c, bottom_drawn_c;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= csr_pkg::SCREEN_WIDTH_RST;
			height_q <= csr_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csr_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				csr_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign r_sat = (cmd.radius > csr_pkg::RAD_W'(MAX_RADIUS)) ?
		csr_pkg::RAD_W'(MAX_RADIUS) : cmd.radius;
	assign r_sq     = csr_pkg::RADICAND_W'(r_sat) * csr_pkg::RADICAND_W'(r_sat);
	assign n_next   = n_q - csr_pkg::RADICAND_W'({dy_q, 1'b1});
	assign last_row = (dy_q == r_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csr_pkg::ST_IDLE: if (cmd.valid) state_d = csr_pkg::ST_ROOT;
			csr_pkg::ST_ROOT: if (sq_rsp.done) state_d = csr_pkg::ST_EMIT;
			csr_pkg::ST_EMIT: begin
				if (!out_valid_q || span.ready) begin
					state_d = last_row ? csr_pkg::ST_IDLE : csr_pkg::ST_ROOT;
				end
			end
			default: state_d = csr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready       = 1'b0;
		emit_fire       = 1'b0;
		sq_req.start    = 1'b0;
		sq_req.radicand = r_sq;
		unique case (state_q)
			csr_pkg::ST_IDLE: begin
				cmd.ready    = 1'b1;
				sq_req.start = cmd.valid;
			end
			csr_pkg::ST_ROOT: ;
			csr_pkg::ST_EMIT: begin
				emit_fire       = !out_valid_q || span.ready;
				sq_req.start    = emit_fire && !last_row;
				sq_req.radicand = n_next;
			end
			default: ;
		endcase
	end

	assign cmd_fire = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_pkg::ST_IDLE;
			dy_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_fire) begin
				dy_q <= '0;
			end else if (emit_fire) begin
				dy_q <= dy_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cx_q    <= cmd.center_x;
			cy_q    <= cmd.center_y;
			color_q <= cmd.fill_color;
			r_q     <= r_sat;
			n_q     <= r_sq;
		end else if (emit_fire) begin
			n_q <= n_next;
		end
	end

	csr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// span clipping
	assign dx_ext   = csr_pkg::COORD_W'(sq_rsp.root);
	assign dy_ext   = csr_pkg::COORD_W'(dy_q);
	assign start_ok = cx_q >= dx_ext;
	assign start_c  = start_ok ? (cx_q - dx_ext) : '0;
	assign top_ok   = cy_q >= dy_ext;
	assign top_c    = top_ok ? (cy_q - dy_ext) : '0;
	assign bottom_c = csr_pkg::BOTTOM_W'(cy_q) + csr_pkg::BOTTOM_W'(dy_q);
	assign col_ok   = start_ok && (start_c < width_q);
	assign top_drawn_c    = col_ok && top_ok && (top_c < height_q);
	assign bottom_drawn_c = col_ok && (dy_q != '0) &&
		(bottom_c < csr_pkg::BOTTOM_W'(height_q));
	assign len_full = {sq_rsp.root, 1'b1};
	assign end_c    = csr_pkg::BOTTOM_W'(start_c) + csr_pkg::BOTTOM_W'(len_full);

	always_comb begin
		len_c = len_full;
		if (col_ok && (end_c > csr_pkg::BOTTOM_W'(width_q))) begin
			len_c = csr_pkg::LEN_W'(width_q - start_c);
		end
		if (!top_drawn_c && !bottom_drawn_c) begin
			len_c = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			top_q          <= top_c;
			bottom_q       <= bottom_c;
			start_q        <= start_c;
			len_q          <= len_c;
			scolor_q       <= color_q;
			top_drawn_q    <= top_drawn_c;
			bottom_drawn_q <= bottom_drawn_c;
			last_q         <= last_row;
		end
	end

	assign span.valid        = out_valid_q;
	assign span.top_row      = top_q;
	assign span.bottom_row   = bottom_q;
	assign span.span_start   = start_q;
	assign span.span_length  = len_q;
	assign span.span_color   = scolor_q;
	assign span.top_drawn    = top_drawn_q;
	assign span.bottom_drawn = bottom_drawn_q;
	assign span.last_span    = last_q;

	`CSR_ASSERT_IMPL(a_done_in_root, sq_rsp.done, state_q == csr_pkg::ST_ROOT)
	`CSR_ASSERT_NEXT(a_last_to_idle, emit_fire && last_row, state_q == csr_pkg::ST_IDLE)
	`CSR_ASSERT_IMPL(a_dy_range, state_q != csr_pkg::ST_IDLE, dy_q <= r_q)

endmodule

@@ test/tb_circle_span_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle span rasterizer testbench
// Sends filled-circle commands under random gaps and output stalls, predicts
// every clipped row span from the centre, radius and screen size, and checks
// each span transfer field by field against the oldest predicted span.
// ----------------------------------------------------------------------------
module tb_circle_span_rasterizer;

	localparam int MAX_RADIUS   = 63;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD    = 600;

	typedef struct packed {
		logic [csr_pkg::COORD_W-1:0] cx;
		logic [csr_pkg::COORD_W-1:0] cy;
		logic [csr_pkg::RAD_W-1:0]   radius;
		logic [csr_pkg::COLOR_W-1:0] color;
	} circle_t;

	typedef struct packed {
		logic [csr_pkg::COORD_W-1:0]  top_row;
		logic [csr_pkg::BOTTOM_W-1:0] bottom_row;
		logic [csr_pkg::COORD_W-1:0]  span_start;
		logic [csr_pkg::LEN_W-1:0]    span_length;
		logic [csr_pkg::COLOR_W-1:0]  span_color;
		logic                         top_drawn;
		logic                         bottom_drawn;
		logic                         last_span;
	} span_t;

	class span_scoreboard;
		span_t expected_q[$];
		int    screen_w;
		int    screen_h;
		int    errors;

		function new();
			screen_w = int'(csr_pkg::SCREEN_WIDTH_RST);
			screen_h = int'(csr_pkg::SCREEN_HEIGHT_RST);
			errors   = 0;
		endfunction

		function void set_screen(input int w, input int h);
			screen_w = w;
			screen_h = h;
		endfunction

		function int isqrt(input int n);
			int root;
			int probe;
			int trial;
			root = 0;
			for (probe = 64; probe != 0; probe = probe >> 1) begin
				trial = root | probe;
				if (trial * trial <= n)
					root = trial;
			end
			return root;
		endfunction

		function void note_circle(input circle_t c);
			int    r, dy, dx, len, cx, cy, start, top, bottom;
			bit    start_ok, top_ok, col_ok;
			span_t s;
			cx = int'(c.cx);
			cy = int'(c.cy);
			r  = int'(c.radius);
			if (r > MAX_RADIUS)
				r = MAX_RADIUS;
			for (dy = 0; dy <= r; dy++) begin
				dx       = isqrt(r * r - dy * dy);
				len      = 2 * dx + 1;
				start_ok = cx >= dx;
				start    = start_ok ? cx - dx : 0;
				top_ok   = cy >= dy;
				top      = top_ok ? cy - dy : 0;
				bottom   = cy + dy;
				col_ok   = start_ok && start < screen_w;
				s.top_drawn    = col_ok && top_ok && top < screen_h;
				s.bottom_drawn = col_ok && dy > 0 && bottom < screen_h;
				if (col_ok && start + len > screen_w)
					len = screen_w - start;
				if (!s.top_drawn && !s.bottom_drawn)
					len = 0;
				s.top_row     = csr_pkg::COORD_W'(top);
				s.bottom_row  = csr_pkg::BOTTOM_W'(bottom);
				s.span_start  = csr_pkg::COORD_W'(start);
				s.span_length = csr_pkg::LEN_W'(len);
				s.span_color  = c.color;
				s.last_span   = (dy == r);
				expected_q.push_back(s);
			end
		endfunction

		function void compare(input string field, input logic [31:0] exp, input logic [31:0] got);
			if (got !== exp) begin
				$error("%s: expected %0d, got %0d", field, exp, got);
				errors++;
			end
		endfunction

		function void check_span(input span_t got);
			span_t exp;
			if (expected_q.size() == 0) begin
				$error("span transfer with no span expected");
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			compare("top_row", 32'(exp.top_row), 32'(got.top_row));
			compare("bottom_row", 32'(exp.bottom_row), 32'(got.bottom_row));
			compare("span_start", 32'(exp.span_start), 32'(got.span_start));
			compare("span_length", 32'(exp.span_length), 32'(got.span_length));
			compare("span_color", 32'(exp.span_color), 32'(got.span_color));
			compare("top_drawn", 32'(exp.top_drawn), 32'(got.top_drawn));
			compare("bottom_drawn", 32'(exp.bottom_drawn), 32'(got.bottom_drawn));
			compare("last_span", 32'(exp.last_span), 32'(got.last_span));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [csr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [csr_pkg::CFG_DATA_W-1:0] cfg_data;
	bit                             hold_request = 1'b0;
	int                             cycle_count = 0;
	span_scoreboard                 sb;

	csr_cmd_if  cmd_ch();
	csr_span_if span_ch();

	circle_span_rasterizer #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.span     (span_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		circle_t c;
		span_t   s;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			c.cx     = cmd_ch.center_x;
			c.cy     = cmd_ch.center_y;
			c.radius = cmd_ch.radius;
			c.color  = cmd_ch.fill_color;
			sb.note_circle(c);
		end
		if (arst_n && span_ch.valid && span_ch.ready) begin
			s.top_row      = span_ch.top_row;
			s.bottom_row   = span_ch.bottom_row;
			s.span_start   = span_ch.span_start;
			s.span_length  = span_ch.span_length;
			s.span_color   = span_ch.span_color;
			s.top_drawn    = span_ch.top_drawn;
			s.bottom_drawn = span_ch.bottom_drawn;
			s.last_span    = span_ch.last_span;
			sb.check_span(s);
		end
	end

	// receiver: stretches of full rate, light stalls, heavy stalls, one long hold
	initial begin : span_ready_gen
		int hold_left;
		int stretch_left;
		int ready_mode;
		hold_left    = 0;
		stretch_left = 0;
		ready_mode   = 0;
		span_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				span_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
				span_ch.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(5, 60);
					ready_mode   = $urandom_range(0, 5);
				end
				stretch_left--;
				case (ready_mode)
					0, 1: span_ch.ready <= 1'b1;
					2, 3: span_ch.ready <= ($urandom_range(0, 3) != 0);
					4: span_ch.ready <= ($urandom_range(0, 3) == 0);
					default: span_ch.ready <= ($urandom_range(0, 29) == 0);
				endcase
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 50);
	endfunction

	function automatic logic [csr_pkg::COORD_W-1:0] pick_coord(input int lim);
		int lo;
		int hi;
		lo = (lim > 70) ? lim - 70 : 0;
		hi = (lim + 70 > 4095) ? 4095 : lim + 70;
		case ($urandom_range(0, 3))
			0: return csr_pkg::COORD_W'($urandom_range(0, 4095));
			1: return csr_pkg::COORD_W'($urandom_range(0, 70));
			2: return csr_pkg::COORD_W'($urandom_range(hi, lo));
			default: return csr_pkg::COORD_W'($urandom_range(0, lim));
		endcase
	endfunction

	function automatic circle_t random_circle(input int w, input int h);
		circle_t c;
		c.cx     = pick_coord(w);
		c.cy     = pick_coord(h);
		c.radius = ($urandom_range(0, 2) == 0) ? csr_pkg::RAD_W'($urandom_range(0, 63)) :
			csr_pkg::RAD_W'($urandom_range(0, 12));
		c.color  = csr_pkg::COLOR_W'($urandom_range(0, 65535));
		return c;
	endfunction

	// call right after a rising edge
	task automatic send_circle(input circle_t c);
		int gap;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.center_x   <= c.cx;
		cmd_ch.center_y   <= c.cy;
		cmd_ch.radius     <= c.radius;
		cmd_ch.fill_color <= c.color;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		int k;
		for (k = 0; k < count; k++)
			send_circle(random_circle(sb.screen_w, sb.screen_h));
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_screen(input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= csr_pkg::REG_SCREEN_WIDTH;
		cfg_data  <= csr_pkg::CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= csr_pkg::REG_SCREEN_HEIGHT;
		cfg_data  <= csr_pkg::CFG_DATA_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_screen(w, h);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int p;
		int w;
		int h;
		sb = new();
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.center_x   <= '0;
		cmd_ch.center_y   <= '0;
		cmd_ch.radius     <= '0;
		cmd_ch.fill_color <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= csr_pkg::REG_SCREEN_WIDTH;
		cfg_data          <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset screen size 800 x 600
		send_circle('{12'd0, 12'd0, 6'd0, 16'h0000});
		send_circle('{12'd4095, 12'd4095, 6'd0, 16'hFFFF});
		send_circle('{12'd400, 12'd300, 6'd63, 16'hA5A5});
		send_circle('{12'd0, 12'd0, 6'd63, 16'h5A5A});
		send_circle('{12'd10, 12'd10, 6'd63, 16'hF800});
		send_circle('{12'd799, 12'd599, 6'd63, 16'h07E0});
		send_circle('{12'd800, 12'd300, 6'd5, 16'h001F});
		send_circle('{12'd797, 12'd300, 6'd5, 16'h1234});
		send_circle('{12'd300, 12'd599, 6'd5, 16'h8001});
		send_circle('{12'd300, 12'd600, 6'd5, 16'h7FFE});
		send_circle('{12'd4095, 12'd4095, 6'd63, 16'hFFFF});
		send_circle('{12'd1, 12'd1, 6'd1, 16'h0F0F});
		send_circle('{12'd2, 12'd598, 6'd2, 16'hF0F0});
		send_circle('{12'd803, 12'd3, 6'd3, 16'hC3C3});
		send_circle('{12'd4095, 12'd0, 6'd4, 16'h3C3C});
		send_random(25);
		drain();

		// largest screen, with one long output hold while commands keep coming
		write_screen(4095, 4095);
		hold_request = 1'b1;
		send_circle('{12'd4090, 12'd4090, 6'd63, 16'hBEEF});
		send_circle('{12'd4095, 12'd0, 6'd63, 16'h0001});
		send_circle('{12'd4032, 12'd4032, 6'd63, 16'h8000});
		send_circle('{12'd63, 12'd63, 6'd63, 16'h4321});
		send_circle('{12'd4095, 12'd4095, 6'd1, 16'hFFFE});
		send_random(25);
		drain();

		// zero screen clears the drawn flags of every span
		write_screen(0, 0);
		send_random(8);
		drain();

		// single pixel screen
		write_screen(1, 1);
		send_circle('{12'd0, 12'd0, 6'd0, 16'h1111});
		send_circle('{12'd0, 12'd0, 6'd3, 16'h2222});
		send_circle('{12'd1, 12'd0, 6'd0, 16'h3333});
		send_random(10);
		drain();

		for (p = 0; p < 4; p++) begin
			w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095) : $urandom_range(16, 200);
			h = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095) : $urandom_range(16, 200);
			write_screen(w, h);
			send_random(20);
			drain();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
